FILE: rtl/tmm_pkg.sv
// Package for the targeted message mailbox: message entry type, cell command
// struct, status codes and stream widths.
// No dependencies; used by every module of the mailbox.
package tmm_pkg;

    // Default number of message cells in the store.
    localparam int QueueDepthDefault = 64;

    // Field widths.
    localparam int IdW   = 16;
    localparam int TypeW = 8;
    localparam int ArgW  = 64;
    localparam int StatW = 2;

    // Stream data widths (fields packed from the lowest bit, padded to bytes).
    localparam int InFieldsW  = 1 + IdW + IdW + TypeW + 3 * ArgW;
    localparam int InDataW    = ((InFieldsW + 7) / 8) * 8;
    localparam int OutFieldsW = StatW + IdW + TypeW + 3 * ArgW;
    localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;

    // Status codes.
    localparam logic [StatW-1:0] ST_OK      = 2'd0;
    localparam logic [StatW-1:0] ST_INVALID = 2'd1;
    localparam logic [StatW-1:0] ST_FULL    = 2'd2;
    localparam logic [StatW-1:0] ST_EMPTY   = 2'd3;

    // Action codes.
    localparam logic ACT_SEND    = 1'b0;
    localparam logic ACT_RECEIVE = 1'b1;

    // One stored message.
    typedef struct packed {
        logic [IdW-1:0]   target;
        logic [IdW-1:0]   source;
        logic [TypeW-1:0] mtype;
        logic [ArgW-1:0]  arg_a;
        logic [ArgW-1:0]  arg_b;
        logic [ArgW-1:0]  arg_c;
    } entry_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic           capture;     // latch match flags against req_target
        logic [IdW-1:0] req_target;
        logic           push;        // append wr_entry at the first free cell
        logic           pop;         // remove the oldest matching message
        entry_t         wr_entry;
    } cmd_t;

endpackage

FILE: rtl/tmm_cell.sv
// One message cell of the mailbox chain: holds one entry and its valid bit,
// matches it against a requester and takes its upper neighbor on removal.
// Depends on tmm_pkg.
module tmm_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  tmm_pkg::cmd_t   cmd,
    input  logic            prev_valid,   // valid bit of the cell below
    input  logic            kill_in,      // a match exists in a lower cell
    input  tmm_pkg::entry_t nxt_entry,    // entry of the cell above
    input  logic            nxt_valid,    // valid bit of the cell above
    output logic            kill_out,
    output logic            valid,
    output tmm_pkg::entry_t entry,
    output tmm_pkg::entry_t sel_entry     // this entry if it is the first match
);

    logic            valid_reg;
    logic            valid_next;
    logic            hit_reg;
    logic            hit_next;
    tmm_pkg::entry_t entry_reg;
    tmm_pkg::entry_t entry_next;
    logic            shift_here;
    logic            load_here;

    // Removal shifts every cell at or above the first match down by one.
    assign kill_out   = kill_in | hit_reg;
    assign shift_here = cmd.pop & kill_out;
    assign load_here  = cmd.push & ~valid_reg & prev_valid;

    // Next state of the cell.
    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        hit_next   = hit_reg;
        if (shift_here)
        begin
            valid_next = nxt_valid;
            entry_next = nxt_entry;
        end
        else if (load_here)
        begin
            valid_next = 1'b1;
            entry_next = cmd.wr_entry;
        end
        if (cmd.capture)
        begin
            hit_next = valid_reg & (entry_reg.target == cmd.req_target);
        end
    end

    // Control bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign valid     = valid_reg;
    assign entry     = entry_reg;
    assign sel_entry = (hit_reg & ~kill_in) ? entry_reg : '0;

endmodule

FILE: rtl/targeted_message_mailbox_top.sv
// Targeted message mailbox: a chain of QUEUE_DEPTH message cells in arrival order.
// The result is registered: an accepted transaction moves the controller to S_BUSY,
// and m_tvalid rises once the output is free. On accept the match flags are
// latched in all cells; S_BUSY appends a send, or pops the first match and compacts the chain.
// A stalled result holds the next transaction in work and keeps s_tready low.
// Reset empties the store and clears session_id; no clearing pass is needed.
module targeted_message_mailbox_top #(
    parameter int QUEUE_DEPTH = tmm_pkg::QueueDepthDefault
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration: session_id.
    input  logic                         cfg_we,
    input  logic [tmm_pkg::IdW-1:0]      cfg_data,
    // Input: action, source_id, target_id, msg_type, arg_a, arg_b, arg_c.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [tmm_pkg::InDataW-1:0]  s_tdata,
    // Output: status, got_source, got_type, got_a, got_b, got_c.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [tmm_pkg::OutDataW-1:0] m_tdata
);

    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CntW-1:0] FullCount = CntW'(QUEUE_DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_BUSY = 1'b1;

    // Unpacked input fields.
    logic                       in_action;
    logic [tmm_pkg::IdW-1:0]    in_source;
    logic [tmm_pkg::IdW-1:0]    in_target;
    logic [tmm_pkg::TypeW-1:0]  in_type;
    logic [tmm_pkg::ArgW-1:0]   in_a;
    logic [tmm_pkg::ArgW-1:0]   in_b;
    logic [tmm_pkg::ArgW-1:0]   in_c;

    assign in_action = s_tdata[0];
    assign in_source = s_tdata[16:1];
    assign in_target = s_tdata[32:17];
    assign in_type   = s_tdata[40:33];
    assign in_a      = s_tdata[104:41];
    assign in_b      = s_tdata[168:105];
    assign in_c      = s_tdata[232:169];

    logic                        state_reg;
    logic                        state_next;
    logic [tmm_pkg::IdW-1:0]     session_reg;
    logic [CntW-1:0]             count_reg;
    logic [CntW-1:0]             count_next;
    logic                        req_action_reg;
    tmm_pkg::entry_t             req_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [tmm_pkg::OutDataW-1:0] out_data_reg;
    logic [tmm_pkg::OutDataW-1:0] out_data_next;

    logic                        accept;
    logic                        out_free;
    logic                        work;
    tmm_pkg::cmd_t               cmd;
    logic [tmm_pkg::StatW-1:0]   status;
    logic [tmm_pkg::IdW-1:0]     send_target;
    tmm_pkg::entry_t             found;
    logic                        any_hit;

    logic                        valid_w [QUEUE_DEPTH];
    logic                        kill_w  [QUEUE_DEPTH];
    tmm_pkg::entry_t             entry_w [QUEUE_DEPTH];
    tmm_pkg::entry_t             sel_w   [QUEUE_DEPTH];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign out_free = ~out_valid_reg | m_tready;
    assign work     = (state_reg == S_BUSY) & out_free;
    assign any_hit  = kill_w[QUEUE_DEPTH-1];

    // Session register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_reg <= '0;
        end
        else if (cfg_we)
        begin
            session_reg <= cfg_data;
        end
    end

    // Request holding register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_action_reg <= in_action;
            req_reg        <= '{target: in_target, source: in_source, mtype: in_type,
                                arg_a: in_a, arg_b: in_b, arg_c: in_c};
        end
    end

    // Resolve the transaction and build the cell command.
    assign send_target = (req_reg.target == '0) ? session_reg : req_reg.target;

    always_comb
    begin
        cmd                     = '0;
        cmd.capture             = accept;
        cmd.req_target          = in_target;
        cmd.wr_entry            = req_reg;
        cmd.wr_entry.target     = send_target;
        status                  = tmm_pkg::ST_OK;
        if (req_action_reg == tmm_pkg::ACT_SEND)
        begin
            if ((req_reg.source == '0) || (req_reg.mtype == '0) || (send_target == '0))
            begin
                status = tmm_pkg::ST_INVALID;
            end
            else if (count_reg == FullCount)
            begin
                status = tmm_pkg::ST_FULL;
            end
            else
            begin
                cmd.push = work;
            end
        end
        else
        begin
            if (req_reg.target == '0)
            begin
                status = tmm_pkg::ST_INVALID;
            end
            else if (!any_hit)
            begin
                status = tmm_pkg::ST_EMPTY;
            end
            else
            begin
                cmd.pop = work;
            end
        end
    end

    // Pick the first matching entry out of the chain.
    always_comb
    begin
        found = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            found = found | sel_w[i];
        end
    end

    // Controller, fill count and output register.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            state_next = S_BUSY;
        end
        if (work)
        begin
            state_next     = S_IDLE;
            out_valid_next = 1'b1;
            out_data_next  = '0;
            out_data_next[1:0] = status;
            if (cmd.pop)
            begin
                out_data_next[217:2] = {found.arg_c, found.arg_b, found.arg_a,
                                        found.mtype, found.source};
                count_next = count_reg - 1'b1;
            end
            if (cmd.push)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Chain of message cells, oldest message in cell 0.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic            prev_valid;
        logic            kill_in;
        tmm_pkg::entry_t nxt_entry;
        logic            nxt_valid;

        if (i == 0)
        begin : g_first
            assign prev_valid = 1'b1;
            assign kill_in    = 1'b0;
        end
        else
        begin : g_mid
            assign prev_valid = valid_w[i-1];
            assign kill_in    = kill_w[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign nxt_entry = '0;
            assign nxt_valid = 1'b0;
        end
        else
        begin : g_inner
            assign nxt_entry = entry_w[i+1];
            assign nxt_valid = valid_w[i+1];
        end

        tmm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .prev_valid (prev_valid),
            .kill_in    (kill_in),
            .nxt_entry  (nxt_entry),
            .nxt_valid  (nxt_valid),
            .kill_out   (kill_w[i]),
            .valid      (valid_w[i]),
            .entry      (entry_w[i]),
            .sel_entry  (sel_w[i])
        );
    end

endmodule

FILE: rtl/tmm_checker.sv
// Port-level checker for the targeted message mailbox, bound to the top level.
// Depends on tmm_pkg and targeted_message_mailbox_top.
module tmm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [tmm_pkg::InDataW-1:0]  s_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [tmm_pkg::OutDataW-1:0] m_tdata
);

    // Only one transaction is in flight: the input closes after an accept.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a transaction was in flight");

    // A new result only appears after the block was busy.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a transaction in work");

    // Any status other than ok carries zero message fields.
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] != tmm_pkg::ST_OK)) |-> (m_tdata[217:2] == '0))
        else $error("failed transaction returned message data");

    // A stalled result holds its data.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind targeted_message_mailbox_top tmm_checker u_tmm_checker (.*);
